[hdl/wpd_pkg.sv]
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants of the windowed peak detector.
// ----------------------------------------------------------------------------
package wpd_pkg;

    // Fixed field widths of the sample, result and configuration channels
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 24;
    localparam int HW_BITS     = 4;

    // Default deepest supported half window
    localparam int MAX_HALF_WINDOW_DEF = 15;

    // Half window after reset
    localparam logic [HW_BITS-1:0] HALF_WINDOW_RESET = 4'd3;

    // One input transaction
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          end_of_series;
    } in_item_t;

    // One result transaction
    typedef struct packed {
        logic [INDEX_BITS-1:0] peak_index;
        logic                  last_of_run;
    } out_item_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_SCAN = 3'b010,
        ST_TAIL = 3'b100
    } wpd_state_t;

endpackage

[hdl/windowed_peak_detector.sv]
// Output: a peak decided by a sample appears on m_* in the cycle after that sample is accepted.
// Throughput: one sample per cycle while running, unless m_* stalls (parallel window compare).
// End of series: s_ready stays low while the pending candidates are checked one per cycle
//   (the output can stall) through the shared compare unit, then a tail state closes the run.
// Reset: synchronous active-low aresetn clears the series, candidates and output; half_window = 3.
// ----------------------------------------------------------------------------
// windowed_peak_detector
// Streams signed samples, finds local maxima that no sample within half_window
// places exceeds, and reports their 1-based indices.
// ----------------------------------------------------------------------------
module windowed_peak_detector #(
    parameter int MAX_HALF_WINDOW = wpd_pkg::MAX_HALF_WINDOW_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wpd_pkg::HW_BITS-1:0]     cfg_data,
    // sample stream
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wpd_pkg::in_item_t               s_data,
    // peak stream
    output logic                            m_valid,
    input  logic                            m_ready,
    output wpd_pkg::out_item_t              m_data
);

    localparam int SB    = wpd_pkg::SAMPLE_BITS;
    localparam int IB    = wpd_pkg::INDEX_BITS;
    localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
    localparam int KW    = $clog2(MAX_HALF_WINDOW + 1);
    localparam int OW    = $clog2(DEPTH);
    localparam int HLW   = $clog2(DEPTH + 1);
    localparam int MW    = MAX_HALF_WINDOW + 1;
    localparam int CW    = IB + 1;

    localparam logic [CW-1:0]  INDEX_MAX = {1'b0, {IB{1'b1}}};
    localparam logic [CW-1:0]  COUNT_CAP = INDEX_MAX + CW'(MAX_HALF_WINDOW + 1);
    localparam logic [CW-1:0]  DEPTH_C   = CW'(DEPTH);
    localparam logic [HLW-1:0] DEPTH_H   = HLW'(DEPTH);
    localparam logic [7:0]     MAXHW_8   = 8'(MAX_HALF_WINDOW);

    // registers
    logic [wpd_pkg::HW_BITS-1:0] hw_reg;
    logic signed [SB-1:0]        hist_reg [DEPTH];
    logic [MW-1:0]               marks_reg,  marks_next;
    logic signed [1:0]           slope_reg,  slope_next;
    logic [CW-1:0]               count_reg,  count_next;
    wpd_pkg::wpd_state_t         state_reg,  state_next;
    logic [KW-1:0]               k_reg;
    logic                        pend_valid_reg, pend_valid_next;
    logic [IB-1:0]               pend_idx_reg;
    logic                        m_valid_reg, m_valid_next;
    wpd_pkg::out_item_t          m_data_reg;

    // combinational
    logic [KW-1:0]               m_val, d_val;
    logic [7:0]                  hw_8;
    logic signed [SB-1:0]        x;
    logic signed [SB-1:0]        hist_new [DEPTH];
    logic signed [1:0]           slope_new;
    logic                        cand;
    logic [CW-1:0]               count_inc;
    logic [MW-1:0]               marks_sh, marks_keep;
    logic                        scanning, out_free, accept;
    logic signed [SB-1:0]        hsel [DEPTH];
    logic [KW-1:0]               ksel;
    logic [CW-1:0]               csel, diff;
    logic [HLW-1:0]              held;
    logic signed [SB-1:0]        ref_val;
    logic                        peak, mark_sel, hit;
    logic [IB-1:0]               idx;
    logic                        load_out;
    wpd_pkg::out_item_t          load_data;
    logic                        advance;

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign scanning = (state_reg == wpd_pkg::ST_SCAN);
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == wpd_pkg::ST_RUN) && out_free;
    assign accept   = s_valid && s_ready;
    assign advance  = out_free;

    // effective half window and decision delay
    always_comb begin
        hw_8  = {4'b0, hw_reg};
        m_val = (hw_8 > MAXHW_8) ? KW'(MAX_HALF_WINDOW) : hw_8[KW-1:0];
        d_val = (m_val == '0) ? KW'(1) : m_val;
    end

    // history shift, slope and candidate marking for the incoming sample
    always_comb begin
        x = s_data.sample;
        hist_new[0] = x;
        for (int i = 1; i < DEPTH; i++) begin
            hist_new[i] = hist_reg[i-1];
        end
        if (x > hist_reg[0]) begin
            slope_new = 2'sd1;
        end else if (x < hist_reg[0]) begin
            slope_new = -2'sd1;
        end else begin
            slope_new = 2'sd0;
        end
        cand      = (count_reg >= CW'(2)) && (slope_new < slope_reg);
        count_inc = (count_reg < COUNT_CAP) ? count_reg + CW'(1) : count_reg;
        marks_sh  = {marks_reg[MW-2:0], 1'b0};
        marks_sh[1] = marks_sh[1] | cand;
        for (int i = 0; i < MW; i++) begin
            marks_keep[i] = (i < int'(d_val));
        end
    end

    // shared window check: new history while running, stored history while scanning
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hsel[i] = scanning ? hist_reg[i] : hist_new[i];
        end
        ksel     = scanning ? k_reg : d_val;
        csel     = scanning ? count_reg : count_inc;
        mark_sel = scanning ? marks_reg[ksel] : marks_sh[ksel];
        held     = (csel < DEPTH_C) ? csel[HLW-1:0] : DEPTH_H;
        ref_val  = hsel[OW'(ksel)];
        peak     = 1'b1;
        for (int o = 0; o < DEPTH; o++) begin
            if ((o + int'(m_val) >= int'(ksel)) && (o <= int'(ksel) + int'(m_val)) &&
                (o < int'(held)) && (hsel[o] > ref_val)) begin
                peak = 1'b0;
            end
        end
        hit  = mark_sel && peak;
        diff = csel - CW'(ksel);
        idx  = (diff > INDEX_MAX) ? {IB{1'b1}} : diff[IB-1:0];
    end

    // sequencer and next-state logic
    always_comb begin
        state_next      = state_reg;
        marks_next      = marks_reg;
        slope_next      = slope_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        load_out        = 1'b0;
        load_data       = '{peak_index: idx, last_of_run: 1'b1};
        case (state_reg)
            wpd_pkg::ST_RUN: begin
                if (accept) begin
                    count_next = count_inc;
                    slope_next = (count_reg >= CW'(1)) ? slope_new : slope_reg;
                    if (s_data.end_of_series) begin
                        marks_next      = marks_sh;
                        pend_valid_next = 1'b0;
                        state_next      = wpd_pkg::ST_SCAN;
                    end else begin
                        marks_next = marks_sh & marks_keep;
                        load_out   = hit;
                    end
                end
            end
            wpd_pkg::ST_SCAN: begin
                if (advance) begin
                    if (hit) begin
                        load_out        = pend_valid_reg;
                        load_data       = '{peak_index: pend_idx_reg, last_of_run: 1'b0};
                        pend_valid_next = 1'b1;
                    end
                    if (k_reg == KW'(1)) begin
                        state_next = wpd_pkg::ST_TAIL;
                    end
                end
            end
            wpd_pkg::ST_TAIL: begin
                if (advance) begin
                    load_out        = pend_valid_reg;
                    load_data       = '{peak_index: pend_idx_reg, last_of_run: 1'b1};
                    pend_valid_next = 1'b0;
                    marks_next      = '0;
                    slope_next      = 2'sd0;
                    count_next      = '0;
                    state_next      = wpd_pkg::ST_RUN;
                end
            end
            default: begin
                state_next = wpd_pkg::ST_RUN;
            end
        endcase
        if (load_out) begin
            m_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg         <= wpd_pkg::HALF_WINDOW_RESET;
            state_reg      <= wpd_pkg::ST_RUN;
            marks_reg      <= '0;
            slope_reg      <= 2'sd0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hw_reg <= cfg_data;
            end
            state_reg      <= state_next;
            marks_reg      <= marks_next;
            slope_reg      <= slope_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers: history line, scan pointer, pending and output data
    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_reg <= hist_new;
        end
        if (accept && s_data.end_of_series) begin
            k_reg <= d_val;
        end else if (scanning && advance) begin
            k_reg <= k_reg - KW'(1);
        end
        if (scanning && advance && hit) begin
            pend_idx_reg <= idx;
        end
        if (load_out) begin
            m_data_reg <= load_data;
        end
    end

endmodule
